[sv/assert_macros.svh]
// assertion macros shared by the guider rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain condition, checked every clock outside reset
`define DPG_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define DPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dpg_pkg.sv]
// types and constants for the drift pid pulse guider
`timescale 1ns / 1ps
package dpg_pkg;

  localparam int ERROR_WINDOW_DEF = 100;

  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 9;
  localparam int AVG_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int PULSE_W   = 16;
  localparam int DRIVE_W   = 32;
  localparam int DERIV_W   = 25;
  localparam int PROD_W    = GAIN_W + DERIV_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = SUM_W;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [AVG_W-1:0]          AVG_OVER_RST  = AVG_W'(4);
  localparam logic signed [GAIN_W-1:0]  GAIN_P_RST    = GAIN_W'(256);
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RST    = '0;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RST    = '0;
  localparam logic [PULSE_W-1:0]        PULSE_MIN_RST = '0;
  localparam logic [PULSE_W-1:0]        PULSE_MAX_RST = '1;

  localparam logic signed [SAMPLE_W-1:0] ERR_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] ERR_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_AVG_OVER,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_PULSE_MIN,
    REG_PULSE_MAX,
    REG_DISABLE_WEST,
    REG_DISABLE_EAST
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MSTART,
    ST_MEAN,
    ST_MFIX,
    ST_RING,
    ST_ISTART,
    ST_INTEG,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DRIVE,
    ST_EMIT
  } state_t;

endpackage

[sv/dpg_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module dpg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 100,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/drift_pid_pulse_guider.sv]
// drift pid pulse guider: batch averaging, windowed integral pid and pulse shaping
// Usage
//   Configuration goes through the apb-style port (psel/penable/pwrite/paddr/pwdata),
//   one 32-bit register every 4 bytes, pready tied high, prdata reads back.
//   Write registers only while the block is idle.
//   Drift samples arrive as valid/ready beats on in_valid/in_ready/drift_sample.
//   A sample that does not complete a batch is absorbed into the batch sum.
//   A sample that completes a batch starts the result sequence: a 32-step
//   radix-2 divider forms the batch mean, the error ring in ram is read and
//   rewritten, the same divider forms the windowed mean, and one 16x25
//   multiplier takes three passes for the pid terms. in_ready stays low from
//   the completing beat on and is high again in the cycle after the result is
//   loaded.
//   The result beat waits in an output register, so the next samples are taken
//   while out_ready is low; a later completing batch holds at the final step
//   until the register is free.
//   Reset (rst, synchronous) restores the register defaults and empties the
//   batch and the error ring; ring contents need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drift_pid_pulse_guider #(
  parameter int ERROR_WINDOW = dpg_pkg::ERROR_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dpg_pkg::CFG_AW-1:0]           paddr,
  input  logic [dpg_pkg::CFG_DW-1:0]           pwdata,
  output logic [dpg_pkg::CFG_DW-1:0]           prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dpg_pkg::SAMPLE_W-1:0]  drift_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dpg_pkg::PULSE_W-1:0]          pulse_east,
  output logic [dpg_pkg::PULSE_W-1:0]          pulse_west,
  output logic signed [dpg_pkg::SAMPLE_W-1:0]  average_drift,
  output logic signed [dpg_pkg::DRIVE_W-1:0]   pid_drive
);
  import dpg_pkg::*;

  localparam int FILL_W = $clog2(ERROR_WINDOW + 1);
  localparam int HEAD_W = (ERROR_WINDOW > 1) ? $clog2(ERROR_WINDOW) : 1;
  localparam int DEN_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(ERROR_WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ERROR_WINDOW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // configuration registers
  logic [AVG_W-1:0]          avg_over;
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;
  logic [PULSE_W-1:0]        pulse_min;
  logic [PULSE_W-1:0]        pulse_max;
  logic                      disable_west;
  logic                      disable_east;

  logic     cfg_wr;
  cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_over     <= AVG_OVER_RST;
      gain_p       <= GAIN_P_RST;
      gain_i       <= GAIN_I_RST;
      gain_d       <= GAIN_D_RST;
      pulse_min    <= PULSE_MIN_RST;
      pulse_max    <= PULSE_MAX_RST;
      disable_west <= 1'b0;
      disable_east <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_AVG_OVER:     avg_over     <= pwdata[AVG_W-1:0];
        REG_GAIN_P:       gain_p       <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:       gain_i       <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:       gain_d       <= pwdata[GAIN_W-1:0];
        REG_PULSE_MIN:    pulse_min    <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX:    pulse_max    <= pwdata[PULSE_W-1:0];
        REG_DISABLE_WEST: disable_west <= pwdata[0];
        REG_DISABLE_EAST: disable_east <= pwdata[0];
        default:          avg_over     <= avg_over;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_AVG_OVER:     prdata = CFG_DW'(avg_over);
      REG_GAIN_P:       prdata = CFG_DW'(gain_p);
      REG_GAIN_I:       prdata = CFG_DW'(gain_i);
      REG_GAIN_D:       prdata = CFG_DW'(gain_d);
      REG_PULSE_MIN:    prdata = CFG_DW'(pulse_min);
      REG_PULSE_MAX:    prdata = CFG_DW'(pulse_max);
      REG_DISABLE_WEST: prdata = CFG_DW'(disable_west);
      REG_DISABLE_EAST: prdata = CFG_DW'(disable_east);
      default:          prdata = '0;
    endcase
  end

  // control state
  state_t state;
  state_t state_next;

  logic signed [SUM_W-1:0]    batch_sum;
  logic [CNT_W-1:0]           batch_count;
  logic [FILL_W-1:0]          ring_fill;
  logic [HEAD_W-1:0]          ring_head;
  logic signed [SUM_W-1:0]    ring_sum;
  logic signed [SAMPLE_W-1:0] last_error;

  // shared divider
  logic [DEN_W-1:0]  div_rem;
  logic [SUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_den;
  logic              div_neg;
  logic [STEP_W-1:0] div_cnt;

  // datapath registers
  logic signed [SAMPLE_W-1:0] mean_q;
  logic signed [SAMPLE_W-1:0] err_q;
  logic signed [SAMPLE_W-1:0] integ_q;
  logic signed [DERIV_W-1:0]  deriv_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc;
  logic signed [DRIVE_W-1:0]  drive_q;

  // control outputs
  logic in_take;
  logic div_run;
  logic ram_re;
  logic ram_we;
  logic out_load;

  // batch accumulation
  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0]        count_inc;
  logic                    batch_done;

  assign sample_ext = SUM_W'(drift_sample);
  assign sum_acc    = batch_sum + sample_ext;
  assign count_inc  = batch_count + CNT_W'(1);
  assign batch_done = count_inc > CNT_W'(avg_over);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_run    = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && batch_done) begin
          state_next = ST_MSTART;
        end
      end
      ST_MSTART: begin
        ram_re     = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        div_run = 1'b1;
        if (div_cnt == STEP_LAST) begin
          state_next = ST_MFIX;
        end
      end
      ST_MFIX:   state_next = ST_RING;
      ST_RING: begin
        ram_we     = 1'b1;
        state_next = ST_ISTART;
      end
      ST_ISTART: state_next = ST_INTEG;
      ST_INTEG: begin
        div_run = 1'b1;
        if (div_cnt == STEP_LAST) begin
          state_next = ST_MUL0;
        end
      end
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_DRIVE;
      ST_DRIVE:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_take = in_valid && in_ready;

  // divider operand selection and one restoring step
  logic signed [SUM_W-1:0] div_src;
  logic [SUM_W-1:0]        div_mag;
  logic [DEN_W:0]          rem_sh;
  logic                    rem_fits;
  logic [DEN_W:0]          rem_sub;
  logic signed [SUM_W-1:0] quo_signed;

  assign div_src    = (state == ST_ISTART) ? ring_sum : batch_sum;
  assign div_mag    = div_src[SUM_W-1] ? (~div_src + SUM_W'(1)) : div_src;
  assign rem_sh     = {div_rem, div_quo[SUM_W-1]};
  assign rem_fits   = rem_sh >= {1'b0, div_den};
  assign rem_sub    = rem_sh - {1'b0, div_den};
  assign quo_signed = div_neg ? -signed'(div_quo) : signed'(div_quo);

  always_ff @(posedge clk) begin
    if (state == ST_MSTART || state == ST_ISTART) begin
      div_rem <= '0;
      div_quo <= div_mag;
      div_neg <= div_src[SUM_W-1];
      div_cnt <= '0;
      div_den <= (state == ST_ISTART) ? DEN_W'(ring_fill) : DEN_W'(batch_count);
    end else if (div_run) begin
      div_rem <= rem_fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      div_quo <= {div_quo[SUM_W-2:0], rem_fits};
      div_cnt <= div_cnt + STEP_W'(1);
    end
  end

  // error ring storage
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] old_err;
  logic                       ring_full;

  assign old_err   = signed'(ram_rdata);
  assign ring_full = ring_fill == FILL_FULL;

  dpg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (ERROR_WINDOW)
  ) u_error_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_head),
    .wdata (err_q),
    .re    (ram_re),
    .raddr (ring_head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_sum   <= '0;
      batch_count <= '0;
      ring_fill   <= '0;
      ring_head   <= '0;
      ring_sum    <= '0;
      last_error  <= '0;
    end else begin
      if (in_take) begin
        batch_sum   <= sum_acc;
        batch_count <= count_inc;
      end else if (state == ST_MSTART) begin
        batch_sum   <= '0;
        batch_count <= '0;
      end
      if (state == ST_RING) begin
        ring_sum   <= ring_sum - (ring_full ? SUM_W'(old_err) : '0) + SUM_W'(err_q);
        ring_fill  <= ring_full ? ring_fill : ring_fill + FILL_W'(1);
        ring_head  <= (ring_head == HEAD_LAST) ? '0 : ring_head + HEAD_W'(1);
        last_error <= err_q;
      end
    end
  end

  // shared multiplier, one term per pass
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [DERIV_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_a = gain_i;
        mul_b = DERIV_W'(integ_q);
      end
      ST_MUL2: begin
        mul_a = gain_d;
        mul_b = deriv_q;
      end
      default: begin
        mul_a = gain_p;
        mul_b = DERIV_W'(err_q);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // drive: divide by 2^16 truncating toward zero
  logic signed [ACC_W-FRAC_W-1:0] acc_hi;
  logic                           acc_round;

  assign acc_hi    = acc[ACC_W-1:FRAC_W];
  assign acc_round = acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_MFIX: begin
        mean_q <= quo_signed[SAMPLE_W-1:0];
        err_q  <= (quo_signed[SAMPLE_W-1:0] == ERR_MIN) ? ERR_MAX
                                                         : -quo_signed[SAMPLE_W-1:0];
      end
      ST_RING:  deriv_q <= DERIV_W'(err_q) - DERIV_W'(last_error);
      ST_MUL0: begin
        integ_q <= quo_signed[SAMPLE_W-1:0];
        prod_q  <= mul_p;
      end
      ST_MUL1: begin
        prod_q <= mul_p;
        acc    <= ACC_W'(prod_q);
      end
      ST_MUL2: begin
        prod_q <= mul_p;
        acc    <= acc + ACC_W'(prod_q);
      end
      ST_MUL3:  acc <= acc + ACC_W'(prod_q);
      ST_DRIVE: drive_q <= DRIVE_W'(acc_hi) + DRIVE_W'({1'b0, acc_round});
      default:  acc <= acc;
    endcase
  end

  // pulse shaping: minimum test, then clamp, then disable
  function automatic logic [PULSE_W-1:0] shape_pulse(
    input logic [DRIVE_W-1:0] len,
    input logic [PULSE_W-1:0] lo,
    input logic [PULSE_W-1:0] hi,
    input logic               off
  );
    logic [DRIVE_W-1:0] v;
    v = len;
    if (v < DRIVE_W'(lo)) begin
      v = '0;
    end
    if (v > DRIVE_W'(hi)) begin
      v = DRIVE_W'(hi);
    end
    if (off) begin
      v = '0;
    end
    return v[PULSE_W-1:0];
  endfunction

  logic [DRIVE_W-1:0] east_len;
  logic [DRIVE_W-1:0] west_len;

  assign east_len = (drive_q > 0) ? drive_q : '0;
  assign west_len = (drive_q < 0) ? -drive_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pulse_east    <= shape_pulse(east_len, pulse_min, pulse_max, disable_east);
      pulse_west    <= shape_pulse(west_len, pulse_min, pulse_max, disable_west);
      average_drift <= mean_q;
      pid_drive     <= drive_q;
    end
  end

  `DPG_ASSERT(a_fill_bound, ring_fill <= FILL_FULL, "ring fill beyond window")
  `DPG_ASSERT_IMP(a_idle_count, state == ST_IDLE, !batch_count[CNT_W-1], "idle batch count too large")
  `DPG_ASSERT_IMP(a_result_src, $rose(out_valid), $past(state) == ST_EMIT, "result beat not from emit step")
  `DPG_ASSERT_NXT(a_emit_hold, state == ST_EMIT && out_valid && !out_ready, state == ST_EMIT, "pending result dropped")

endmodule
